// ===== rtl/core/rdr_pkg.sv =====
// shared types, constants and register indexes of the record deframer
`default_nettype none
package rdr_pkg;

  localparam int HDR_BYTES   = 5;
  localparam int FILL_W      = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_KIND = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PCM_KIND     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN      = 2'd2;

  localparam logic MODE_STREAM = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  localparam logic KIND_CONTROL = 1'b0;
  localparam logic KIND_PCM     = 1'b1;

  localparam logic [7:0]  RST_CONTROL_KIND = 8'd1;
  localparam logic [7:0]  RST_PCM_KIND     = 8'd2;
  localparam logic [31:0] RST_MAX_LEN      = 32'd4096;

  typedef struct packed {
    logic [7:0]  control_kind;
    logic [7:0]  pcm_kind;
    logic [31:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        record_kind;
    logic [7:0]  payload_byte;
    logic        first_of_record;
    logic        last_of_record;
    logic        empty_record;
    logic [31:0] resync_count;
    logic [31:0] buffered_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rdr_in_reg.sv =====
// input register of the record deframer
`default_nettype none
module rdr_in_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rdr_pkg::IN_TDATA_W-1:0] in_tdata,  // data_byte
  input  wire logic [rdr_pkg::IN_TUSER_W-1:0] in_tuser,  // mode
  input  wire logic                           advance,
  output logic                                item_valid,
  output rdr_pkg::item_t                      item
);
  import rdr_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_tready  = !vld_r || advance;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode      <= in_tuser[0];
      item_r.data_byte <= in_tdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rdr_step.sv =====
// header hunt, resync and payload tracking for one stream byte per cycle in which fire is high
`default_nettype none
module rdr_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire rdr_pkg::item_t  item,
  input  wire rdr_pkg::cfg_t   cfg,
  output rdr_pkg::result_t     res
);
  import rdr_pkg::*;

  logic [7:0]        win_r   [HDR_BYTES];
  logic [7:0]        win_nxt [HDR_BYTES];
  logic [7:0]        win_wr  [HDR_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              in_payload_r, in_payload_nxt;
  logic              kind_r, kind_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       rcv_r, rcv_nxt;
  logic [31:0]       resync_r, resync_nxt;

  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_inc;
  logic [31:0]       hdr_len;
  logic [31:0]       rem_dec;
  logic              is_ctl, is_pcm, hdr_ok, win_full;
  logic [32:0]       held_sum;
  logic [31:0]       held_sat;

  assign fill_base = (fill_r >= FILL_W'(HDR_BYTES)) ? '0 : fill_r;
  assign fill_inc  = fill_base + FILL_W'(1);
  assign win_full  = (fill_inc == FILL_W'(HDR_BYTES));

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      win_wr[i] = (FILL_W'(i) == fill_base) ? item.data_byte : win_r[i];
    end
  end

  assign hdr_len = {win_wr[4], win_wr[3], win_wr[2], win_wr[1]};
  assign is_ctl  = (win_wr[0] == cfg.control_kind);
  assign is_pcm  = (win_wr[0] == cfg.pcm_kind);
  assign hdr_ok  = (is_ctl || is_pcm) && (hdr_len <= cfg.max_len);
  assign rem_dec = rem_r - 32'd1;

  always_comb begin
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    kind_nxt       = kind_r;
    rem_nxt        = rem_r;
    rcv_nxt        = rcv_r;
    resync_nxt     = resync_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      win_nxt[i] = win_r[i];
    end
    res = '0;

    if (item.mode == MODE_CLEAR) begin
      fill_nxt       = '0;
      in_payload_nxt = 1'b0;
      kind_nxt       = KIND_CONTROL;
      rem_nxt        = '0;
      rcv_nxt        = '0;
      resync_nxt     = '0;
    end else if (in_payload_r) begin
      res.valid           = 1'b1;
      res.record_kind     = kind_r;
      res.payload_byte    = item.data_byte;
      res.first_of_record = (rcv_r == '0);
      rcv_nxt             = rcv_r + 32'd1;
      rem_nxt             = rem_dec;
      if (rem_dec == '0) begin
        res.last_of_record = 1'b1;
        in_payload_nxt     = 1'b0;
        rcv_nxt            = '0;
        fill_nxt           = '0;
      end
    end else begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        win_nxt[i] = win_wr[i];
      end
      fill_nxt = fill_inc;
      if (win_full) begin
        if (!hdr_ok) begin
          // drop the oldest byte and keep hunting
          for (int i = 0; i < HDR_BYTES - 1; i++) begin
            win_nxt[i] = win_wr[i+1];
          end
          fill_nxt   = FILL_W'(HDR_BYTES - 1);
          resync_nxt = resync_r + 32'd1;
        end else begin
          kind_nxt = is_ctl ? KIND_CONTROL : KIND_PCM;
          fill_nxt = '0;
          if (hdr_len == '0) begin
            res.valid          = 1'b1;
            res.record_kind    = kind_nxt;
            res.last_of_record = 1'b1;
            res.empty_record   = 1'b1;
          end else begin
            in_payload_nxt = 1'b1;
            rem_nxt        = hdr_len;
            rcv_nxt        = '0;
          end
        end
      end
    end

    res.resync_count   = resync_nxt;
    res.buffered_count = in_payload_nxt ? held_sat : {{(32-FILL_W){1'b0}}, fill_nxt};
  end

  // header bytes plus bytes seen so far, saturating
  assign held_sum = {1'b0, rcv_nxt} + 33'(HDR_BYTES);
  assign held_sat = held_sum[32] ? '1 : held_sum[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      kind_r       <= KIND_CONTROL;
      rem_r        <= '0;
      rcv_r        <= '0;
      resync_r     <= '0;
    end else if (fire) begin
      fill_r       <= fill_nxt;
      in_payload_r <= in_payload_nxt;
      kind_r       <= kind_nxt;
      rem_r        <= rem_nxt;
      rcv_r        <= rcv_nxt;
      resync_r     <= resync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  a_fill_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(HDR_BYTES))
    else $error("header window fill reached a full window between items");

  a_payload_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (rem_r != '0) && (fill_r == '0))
    else $error("payload phase with nothing remaining or a partly filled window");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.empty_record |-> res.valid && res.last_of_record && !in_payload_r)
    else $error("empty record flagged outside a header accept");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.mode == MODE_CLEAR) |=> (resync_r == '0) && !in_payload_r && (fill_r == '0))
    else $error("clear request left decoder state behind");

endmodule
`default_nettype wire

// ===== rtl/core/record_deframer_resync_top.sv =====
// top level of the record deframer: config registers, input stage, step logic, result register
`default_nettype none
// Splits a byte stream into records of one kind byte, a 32-bit little-endian
// length and the payload, and returns exactly one result per request. A
// request accepted into the input register runs through the header check or
// payload update and lands in the result register once the step logic
// advances, which waits while an earlier result is stalled on out_tready. With
// out_tready high one byte is accepted every cycle.
// A stalled result holds the step logic, and in_tready drops once the input
// register is also occupied and the waiting result is not taken in that cycle.
// A full five-byte window with an unknown kind or a length above the
// configured maximum drops its oldest byte and bumps the resync count. Mode 1
// on the request clears the decoder and the resync count. Configuration
// writes are taken at any time but should only be issued while idle.
module record_deframer_resync_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rdr_pkg::IN_TDATA_W-1:0]     in_tdata,   // data_byte
  input  wire logic [rdr_pkg::IN_TUSER_W-1:0]     in_tuser,   // mode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_valid, payload_byte, first_of_record, resync_count, buffered_count, zero pad
  output logic [rdr_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [rdr_pkg::OUT_TUSER_W-1:0]         out_tuser,  // record_kind, empty_record
  output logic                                    out_tlast,  // last_of_record
  input  wire logic                               cfg_we,
  input  wire logic [rdr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [rdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rdr_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  result_t res;
  result_t res_r;
  logic    item_valid;
  logic    advance;
  logic    out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_kind <= RST_CONTROL_KIND;
      cfg_r.pcm_kind     <= RST_PCM_KIND;
      cfg_r.max_len      <= RST_MAX_LEN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CONTROL_KIND: cfg_r.control_kind <= cfg_wdata[7:0];
        REG_PCM_KIND:     cfg_r.pcm_kind     <= cfg_wdata[7:0];
        REG_MAX_LEN:      cfg_r.max_len      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign advance = item_valid && (!out_vld_r || out_tready);

  rdr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rdr_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = res_r.last_of_record;
  assign out_tuser  = {res_r.empty_record, res_r.record_kind};
  assign out_tdata  = {6'b0, res_r.buffered_count, res_r.resync_count,
                       res_r.first_of_record, res_r.payload_byte, res_r.valid};

endmodule
`default_nettype wire
